FILE: hw/rtl/deq_pkg.sv
// Shared constants and types for the double-ended queue core.
// No dependencies; imported by double_ended_queue_core.
`timescale 1ns / 1ps

package deq_pkg;

    // Field widths of the stream beats.
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes carried in the input tuser; other codes act as a query.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    // Value reported for both ends while the queue is empty.
    localparam logic [VALUE_W-1:0] EMPTY_MARK = 32'hFFFF_FFFF;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DATA = 3'b100
    } t_state;

endpackage

FILE: hw/rtl/deq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit values held in a ring buffer.
// Depends on deq_pkg and two deq_ram instances (front and back read copies).
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake                tuser                     tdata
//  s        in   i_s_tvalid / o_s_tready  op                        value
//  m        out  o_m_tvalid / i_m_tready  is_empty, push_dropped    front, back, count
//
// An operation steps through S_IDLE (accept with index update and RAM write),
// then S_READ (the read of both ends), then S_DATA (the registered read data is
// loaded into the output register).
// Reset (synchronous, active low) empties the queue; RAM contents are kept.
// While an output beat waits, one more operation runs up to the load step;
// the input then stays stalled until the waiting beat is taken.

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // [31:0] value
    input  logic [2:0]   i_s_tuser,   // [2:0] op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,   // [31:0] front_value, [63:32] back_value,
                                      // [68:64] item_count, [71:69] zero
    output logic [1:0]   o_m_tuser    // [0] is_empty, [1] push_dropped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    t_state r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;
    logic          r_out_dropped;
    logic          r_out_valid;
    logic [31:0]   r_out_front;
    logic [31:0]   r_out_back;
    logic [COUNT_W-1:0] r_out_count;
    logic          r_out_empty;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   front_rd;
    logic [31:0]   back_rd;
    logic          accept;
    logic          load_out;
    logic [AW-1:0] front_prev;
    logic [AW-1:0] front_next;
    logic [AW-1:0] back_prev;
    logic [AW-1:0] back_next;
    logic [CW+COUNT_W-1:0] count_wide;
    logic [OP_W-1:0] op;

    assign op       = i_s_tuser;
    assign accept   = i_s_tvalid && o_s_tready;
    assign load_out = (r_state == S_DATA) && (!r_out_valid || i_m_tready);

    // Ring index neighbours with wrap in both directions.
    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign back_prev  = (r_back == '0) ? LAST_IDX : r_back - AW'(1);
    assign back_next  = (r_back == LAST_IDX) ? '0 : r_back + AW'(1);

    // Index, count and write decisions for the accepted operation.
    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_dropped = r_dropped;
        wr_en     = 1'b0;
        wr_addr   = r_front;
        if (accept) begin
            n_dropped = 1'b0;
            priority if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
                priority if (r_count == FULL_CNT) begin
                    n_dropped = 1'b1;
                end else if (r_count == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_front;
                    n_back  = r_front;
                    n_count = ONE_CNT;
                end else if (op == OP_PUSH_FRONT) begin
                    wr_en   = 1'b1;
                    wr_addr = front_prev;
                    n_front = front_prev;
                    n_count = r_count + ONE_CNT;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = back_next;
                    n_back  = back_next;
                    n_count = r_count + ONE_CNT;
                end
            end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
                priority if (r_count == ONE_CNT) begin
                    n_count = '0;
                end else if (r_count != '0) begin
                    if (op == OP_POP_FRONT) begin
                        n_front = front_next;
                    end else begin
                        n_back = back_prev;
                    end
                    n_count = r_count - ONE_CNT;
                end else begin
                    // Popping an empty queue changes nothing.
                    n_count = r_count;
                end
            end else begin
                // Query and unused codes leave the queue as it is.
                n_count = r_count;
            end
        end
    end

    // Sequencer: accept, read both ends, then hand over to the output register.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload, loaded from the RAM read data once the read has landed.
    assign count_wide = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        r_dropped <= n_dropped;
        if (load_out) begin
            r_out_empty   <= (r_count == '0);
            r_out_front   <= (r_count == '0) ? EMPTY_MARK : front_rd;
            r_out_back    <= (r_count == '0) ? EMPTY_MARK : back_rd;
            r_out_count   <= count_wide[COUNT_W-1:0];
            r_out_dropped <= r_dropped;
        end
    end

    // Two copies of the entry store so both ends are read in the same cycle.
    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_addr (r_front),
        .o_rd_data (front_rd)
    );

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_addr (r_back),
        .o_rd_data (back_rd)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_back, r_out_front};
    assign o_m_tuser  = {r_out_dropped, r_out_empty};

endmodule
